// ===== src/bmf_pkg.sv =====
`timescale 1ns / 1ps
// bmf_pkg: shared types and constants of the box mean filter core.
// No dependencies.
package bmf_pkg;

  localparam int CFG_W = 11;
  localparam int PIX_W = 8;
  localparam int KER_W = 3;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_START,
    S_DIV,
    S_OUT
  } bmf_state_e;

endpackage

// ===== src/bmf_div.sv =====
`timescale 1ns / 1ps
// bmf_div: restoring divider, one quotient bit per cycle.
// Depends on bmf_pkg.
module bmf_div import bmf_pkg::*; #(
  parameter int NW = 14,
  parameter int DW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   num_q, num_d;
  logic [DW:0]     rem_q, rem_d;
  logic [DW:0]     rem_s;
  logic            ge;

  always_comb begin
    rem_s  = {rem_q[DW-1:0], num_q[NW-1]};
    ge     = rem_s >= {1'b0, den_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(NW);
      num_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_s - {1'b0, den_i}) : rem_s;
      num_d = {num_q[NW-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== src/box_mean_filter_zero_pad_core.sv =====
`timescale 1ns / 1ps
// box_mean_filter_zero_pad_core: streaming k-by-k box mean with zero padding.
// Depends on bmf_pkg and bmf_div.
//
// channel  | handshake                 | word
// ---------+---------------------------+------------------------
// in       | in_valid_i / in_ready_o   | pixel_i, pad_i
// out      | out_valid_o / out_ready_i | mean_value_o, last_o
// cfg      | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// An input word that makes no output is taken and the core stays idle. One that
// makes an output reads the line store once per window cell, then the divider
// makes one quotient bit per cycle; the sum is SUMW bits (14 at MAX_KERNEL 7).
// Input is taken only in the idle state; a finished mean waits in the output
// register while the next word is taken. Reset is asynchronous, active low;
// the line store is not cleared.
module box_mean_filter_zero_pad_core import bmf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             pad_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] mean_value_o,
  output logic             last_o
);

  localparam int LS_ROWS = 2 * MAX_KERNEL;
  localparam int DEPTH   = LS_ROWS * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int SLW     = $clog2(LS_ROWS);
  localparam int KM      = (MAX_KERNEL > 7) ? 7 : MAX_KERNEL;
  localparam int KMAX    = (KM % 2 == 1) ? KM : KM - 1;
  localparam int WMAX    = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int WRST    = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int RW      = CFG_W + 1;
  localparam int LGW     = CFG_W + 2;
  localparam int SUMW    = $clog2(KMAX * KMAX * 255 + 1);
  localparam int DVW     = $clog2(KMAX * KMAX + 1);

  bmf_state_e state_q, state_d;

  logic [CFG_W-1:0] w_q, ht_q;
  logic [KER_W-1:0] k_q, kc, h;
  logic [LGW-1:0]   lag;

  logic [CW-1:0]    in_col_q;
  logic [RW-1:0]    in_row_q;
  logic [SLW-1:0]   in_slot_q;
  logic [LGW-1:0]   in_cnt_q;
  logic [CW-1:0]    out_col_q;
  logic [CFG_W-1:0] out_row_q;
  logic [SLW-1:0]   out_slot_q;

  logic [KER_W-1:0] dr_q, dc_q;
  logic [RW-1:0]    wr_q;
  logic [CW:0]      wc_q;
  logic [SLW-1:0]   wslot_q;
  logic [SLW:0]     slot_start;
  logic             pend_q, cell_q, cell_ok;
  logic [SUMW-1:0]  sum_q;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    waddr, raddr;

  logic             in_acc, out_load, is_last, emit;
  logic             div_start, div_done;
  logic [SUMW-1:0]  quo;

  assign h   = k_q >> 1;
  assign lag = LGW'(h) * LGW'(w_q) + LGW'(h);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign emit       = in_cnt_q >= lag;
  assign out_load   = (state_q == S_OUT) && (!out_valid_o || out_ready_i);
  assign is_last    = (out_row_q == ht_q - CFG_W'(1)) &&
                      ({1'b0, out_col_q} == (CW+1)'(w_q - CFG_W'(1)));
  assign div_start  = (state_q == S_START);

  always_comb begin
    kc = cfg_data_i[KER_W-1:0];
    if (kc > KER_W'(KMAX)) kc = KER_W'(KMAX);
    if (!kc[0]) kc = (kc == '0) ? KER_W'(1) : kc - KER_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= CFG_W'(WRST);
      ht_q <= CFG_W'(480);
      k_q  <= KER_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH: begin
          if (cfg_data_i == '0) w_q <= CFG_W'(1);
          else if (cfg_data_i > CFG_W'(WMAX)) w_q <= CFG_W'(WMAX);
          else w_q <= cfg_data_i;
        end
        REG_HEIGHT: ht_q <= (cfg_data_i == '0) ? CFG_W'(1) : cfg_data_i;
        REG_KERNEL: k_q <= kc;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && emit) state_d = S_READ;
      S_READ:  if (dr_q == k_q - KER_W'(1) && dc_q == k_q - KER_W'(1)) state_d = S_DRAIN;
      S_DRAIN: state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = in_acc && (in_row_q < RW'(ht_q)) && ({1'b0, in_col_q} < (CW+1)'(w_q));
    mem_re = (state_q == S_READ);
    waddr  = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
    raddr  = AW'(wslot_q) * AW'(MAX_WIDTH) + AW'(wc_q - (CW+1)'(h));
    cell_ok = (wr_q >= RW'(h)) && (wr_q - RW'(h) < RW'(ht_q)) &&
              (wc_q >= (CW+1)'(h)) && ((CW+1)'(wc_q - (CW+1)'(h)) < (CW+1)'(w_q));
    slot_start = {1'b0, out_slot_q} + (SLW+1)'(LS_ROWS) - (SLW+1)'(h);
    if (slot_start >= (SLW+1)'(LS_ROWS)) slot_start = slot_start - (SLW+1)'(LS_ROWS);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= pad_i ? '0 : pixel_i;
    if (mem_re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_cnt_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      dr_q       <= '0;
      dc_q       <= '0;
      pend_q     <= 1'b0;
      cell_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= mem_re;
      cell_q  <= cell_ok;
      out_valid_o <= out_load || (out_valid_o && !out_ready_i);

      if (cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT ||
                       cfg_idx_i == REG_KERNEL)) begin
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        in_cnt_q   <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
      end else if (in_acc) begin
        if (!emit) in_cnt_q <= in_cnt_q + LGW'(1);
        if ({1'b0, in_col_q} >= (CW+1)'(w_q - CFG_W'(1))) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + RW'(1);
          in_slot_q <= (in_slot_q == SLW'(LS_ROWS - 1)) ? '0 : in_slot_q + SLW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end else if (out_load) begin
        if (is_last) begin
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_slot_q  <= '0;
          in_cnt_q   <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_slot_q <= '0;
        end else if ({1'b0, out_col_q} == (CW+1)'(w_q - CFG_W'(1))) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + CFG_W'(1);
          out_slot_q <= (out_slot_q == SLW'(LS_ROWS - 1)) ? '0 : out_slot_q + SLW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end

      if (in_acc && emit) begin
        dr_q <= '0;
        dc_q <= '0;
      end else if (state_q == S_READ) begin
        if (dc_q == k_q - KER_W'(1)) begin
          dc_q <= '0;
          dr_q <= dr_q + KER_W'(1);
        end else begin
          dc_q <= dc_q + KER_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      wr_q    <= RW'(out_row_q);
      wc_q    <= (CW+1)'(out_col_q);
      wslot_q <= SLW'(slot_start);
      sum_q   <= '0;
    end else begin
      if (state_q == S_READ) begin
        if (dc_q == k_q - KER_W'(1)) begin
          wc_q    <= (CW+1)'(out_col_q);
          wr_q    <= wr_q + RW'(1);
          wslot_q <= (wslot_q == SLW'(LS_ROWS - 1)) ? '0 : wslot_q + SLW'(1);
        end else begin
          wc_q <= wc_q + (CW+1)'(1);
        end
      end
      if (pend_q && cell_q) sum_q <= sum_q + SUMW'(rdata_q);
    end
    if (out_load) begin
      mean_value_o <= (quo > SUMW'(255)) ? PIX_W'(255) : quo[PIX_W-1:0];
      last_o       <= is_last;
    end
  end

  bmf_div #(
    .NW (SUMW),
    .DW (DVW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (DVW'(k_q) * DVW'(k_q)),
    .done_o  (div_done),
    .quo_o   (quo)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside divide state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, in_col_q} < (CW+1)'(w_q))
    else $error("input column beyond width");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, out_col_q} < (CW+1)'(w_q))
    else $error("output column beyond width");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> in_cnt_q >= lag)
    else $error("output before window is filled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("store read and write overlap");
`endif

endmodule
